// ----- rtl/core/rpcs_pkg.sv -----
package rpcs_pkg;

  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned ELAPSED_W   = 14;
  localparam int unsigned SINCE_W     = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned MIX_W       = 22;
  localparam int unsigned QUOT_STEPS  = 8;
  localparam int unsigned STEP_W      = 3;
  localparam int unsigned LANES       = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 14'd16383;
  localparam logic [SINCE_W-1:0]   SINCE_MAX   = 3'd7;
  localparam logic [SINCE_W-1:0]   UPDATE_GAP  = 3'd5;

  localparam logic [COUNT_W-1:0]   COUNT_RESET = 5'd2;
  localparam logic [ELAPSED_W-1:0] SHINE_RESET = 14'd300;
  localparam logic [ELAPSED_W-1:0] FADE_RESET  = 14'd300;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
  } item_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_drive;
    logic [CHAN_W-1:0] blue_drive;
    logic [CHAN_W-1:0] green_drive;
  } item_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
  } color_t;

  localparam color_t COLOR_BLACK     = '{red: 8'h00, blue: 8'h00, green: 8'h00};
  localparam color_t COLOR_DIM_GREEN = '{red: 8'h00, blue: 8'h00, green: 8'h10};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_COUNT = 2'd0,
    CFG_SHINE_MS    = 2'd1,
    CFG_FADE_MS     = 2'd2
  } cfg_index_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    TICK_QUIET,
    TICK_MIX,
    TICK_ADVANCE
  } tick_result_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic tick;
    logic write;
    logic rd_en;
    logic rd_nxt;
    logic load_a;
    logic load_b;
    logic mul;
    logic sum;
    logic div_step;
    logic out_load;
    logic out_mix;
  } ctrl_cmd_t;

  typedef struct packed {
    tick_result_e result;
    logic         div_last;
  } dp_status_t;

endpackage

// ----- rtl/core/rpcs_palette.sv -----
module rpcs_palette import rpcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] waddr_i,
  input  color_t                           wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] raddr_i,
  output color_t                           rdata_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

  color_t                   mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written_q;
  color_t                   rdata_q;
  logic                     rvalid_q;
  logic [IDX_W-1:0]         raddr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
      raddr_q <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= written_q[raddr_i];
      end
    end
  end

  // entries never written read back their power-on colors
  always_comb begin
    if (rvalid_q) begin
      rdata_o = rdata_q;
    end else if (raddr_q == IDX_W'(1)) begin
      rdata_o = COLOR_DIM_GREEN;
    end else begin
      rdata_o = COLOR_BLACK;
    end
  end

endmodule

// ----- rtl/core/rpcs_datapath.sv -----
module rpcs_datapath import rpcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_in_t              in_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output item_out_t             out_item_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned SW_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic [COUNT_W-1:0]   color_count_q;
  logic [ELAPSED_W-1:0] shine_q, fade_q;
  logic                 fading_q, fading_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [SINCE_W-1:0]   since_q, since_d, since_inc;
  logic [IDX_W-1:0]     idx_q, idx_d, idx_nxt;
  logic [ELAPSED_W-1:0] e_q;

  logic [CMP_W-1:0]     cnt_use, idx_plus;
  logic [SW_W-1:0]      slot_ext;
  logic                 slot_ok;
  tick_result_e         result;

  color_t               rd_color;
  color_t               a_q, b_q;
  logic [CHAN_W-1:0]    old_ch [LANES];
  logic [CHAN_W-1:0]    new_ch [LANES];
  logic [MIX_W-1:0]     prod_old_q [LANES];
  logic [MIX_W-1:0]     prod_new_q [LANES];
  logic [MIX_W-1:0]     rem_q [LANES];
  logic [CHAN_W-1:0]    quo_q [LANES];
  logic [MIX_W-1:0]     dsr_q;
  logic [STEP_W-1:0]    step_q;
  item_out_t            out_q;

  // count in use, clamped to 1..PALETTE_DEPTH
  always_comb begin
    cnt_use = CMP_W'(color_count_q);
    if (color_count_q == '0) begin
      cnt_use = CMP_W'(1);
    end else if (cnt_use > CMP_W'(PALETTE_DEPTH)) begin
      cnt_use = CMP_W'(PALETTE_DEPTH);
    end
    idx_plus = CMP_W'(idx_q) + CMP_W'(1);
    idx_nxt  = (idx_plus >= cnt_use) ? '0 : idx_plus[IDX_W-1:0];
  end

  assign slot_ext = SW_W'(in_item_i.slot);
  assign slot_ok  = slot_ext < SW_W'(PALETTE_DEPTH);

  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign since_inc   = (since_q == SINCE_MAX) ? since_q : since_q + 1'b1;

  // phase decision for a tick
  always_comb begin
    result    = TICK_QUIET;
    fading_d  = fading_q;
    elapsed_d = elapsed_inc;
    since_d   = since_inc;
    idx_d     = idx_q;
    if (!fading_q) begin
      if (elapsed_inc > shine_q) begin
        fading_d  = 1'b1;
        elapsed_d = '0;
      end
    end else if (fade_q != '0 && elapsed_inc <= fade_q) begin
      if (since_inc >= UPDATE_GAP) begin
        result  = TICK_MIX;
        since_d = '0;
      end
    end else begin
      result    = TICK_ADVANCE;
      fading_d  = 1'b0;
      elapsed_d = '0;
      idx_d     = idx_nxt;
    end
  end

  assign status_o.result   = result;
  assign status_o.div_last = (step_q == STEP_W'(QUOT_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= COUNT_RESET;
      shine_q       <= SHINE_RESET;
      fade_q        <= FADE_RESET;
      fading_q      <= 1'b0;
      elapsed_q     <= '0;
      since_q       <= '0;
      idx_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLOR_COUNT: color_count_q <= cfg_data_i[COUNT_W-1:0];
          CFG_SHINE_MS:    shine_q       <= cfg_data_i[ELAPSED_W-1:0];
          CFG_FADE_MS:     fade_q        <= cfg_data_i[ELAPSED_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick) begin
        fading_q  <= fading_d;
        elapsed_q <= elapsed_d;
        since_q   <= since_d;
        idx_q     <= idx_d;
      end else if (cmd_i.write) begin
        idx_q <= '0;
      end
    end
  end

  rpcs_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cmd_i.write && slot_ok),
    .waddr_i(slot_ext[IDX_W-1:0]),
    .wdata_i('{red: in_item_i.red_in, blue: in_item_i.blue_in,
               green: in_item_i.green_in}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_nxt ? idx_nxt : idx_q),
    .rdata_o(rd_color)
  );

  assign old_ch[0] = a_q.red;
  assign old_ch[1] = a_q.blue;
  assign old_ch[2] = a_q.green;
  assign new_ch[0] = b_q.red;
  assign new_ch[1] = b_q.blue;
  assign new_ch[2] = b_q.green;

  // per-channel lanes: two products, sum, then an 8-step restoring divide by
  // fade_ms; the quotient fits 8 bits since the numerator is below 256*T
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      e_q <= elapsed_inc;
    end
    if (cmd_i.load_a) begin
      a_q <= rd_color;
    end
    if (cmd_i.load_b) begin
      b_q <= rd_color;
    end
    if (cmd_i.sum) begin
      dsr_q  <= MIX_W'(fade_q) << (QUOT_STEPS - 1);
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      dsr_q  <= dsr_q >> 1;
      step_q <= step_q + 1'b1;
    end
    for (int i = 0; i < LANES; i++) begin
      if (cmd_i.mul) begin
        prod_old_q[i] <= MIX_W'(old_ch[i]) * MIX_W'(fade_q - e_q);
        prod_new_q[i] <= MIX_W'(new_ch[i]) * MIX_W'(e_q);
      end
      if (cmd_i.sum) begin
        rem_q[i] <= prod_old_q[i] + prod_new_q[i];
        quo_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        if (rem_q[i] >= dsr_q) begin
          rem_q[i] <= rem_q[i] - dsr_q;
          quo_q[i] <= {quo_q[i][CHAN_W-2:0], 1'b1};
        end else begin
          quo_q[i] <= {quo_q[i][CHAN_W-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_mix) begin
        out_q <= '{red_drive: quo_q[0], blue_drive: quo_q[1], green_drive: quo_q[2]};
      end else begin
        out_q <= '{red_drive: a_q.red, blue_drive: a_q.blue, green_drive: a_q.green};
      end
    end
  end

  assign out_item_o = out_q;

endmodule

// ----- rtl/core/rpcs_ctrl.sv -----
module rpcs_ctrl import rpcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_operation_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   mix_q, mix_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, tick_go, out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign tick_go    = accept && (op_e'(in_operation_i) == OP_TICK);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    mix_d   = mix_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_go && status_i.result != TICK_QUIET) begin
          state_d = ST_READ_A;
          mix_d   = (status_i.result == TICK_MIX);
        end
      end
      ST_READ_A: state_d = ST_LOAD_A;
      ST_LOAD_A: state_d = mix_q ? ST_LOAD_B : ST_OUT;
      ST_LOAD_B: state_d = ST_MUL;
      ST_MUL:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_mix = mix_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.tick  = tick_go;
        cmd_o.write = accept && (op_e'(in_operation_i) == OP_WRITE);
      end
      ST_READ_A: cmd_o.rd_en = 1'b1;
      ST_LOAD_A: begin
        cmd_o.load_a = 1'b1;
        cmd_o.rd_en  = mix_q;
        cmd_o.rd_nxt = 1'b1;
      end
      ST_LOAD_B: cmd_o.load_b   = 1'b1;
      ST_MUL:    cmd_o.mul      = 1'b1;
      ST_SUM:    cmd_o.sum      = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_OUT:    cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // output slot: filled on load, freed on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mix_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mix_q       <= mix_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/rgb_palette_crossfade_sequencer_core.sv -----
// Write items and ticks without a result leave the block idle; the next item is taken right after.
// A tick that ends a fade loads the new color, then puts it in the output register when free.
// A mix tick loads two colors and runs the 8-step restoring divide shared by the three lanes.
// A result waiting in the output register holds off a new result, not new items.
// Async active-low reset: registers to defaults, phase to holding, palette to power-on colors.
module rgb_palette_crossfade_sequencer_core import rpcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  item_in_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output item_out_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rpcs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_operation_i(in_item_i.operation),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  rpcs_datapath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rpcs_pkg::*;

  localparam int unsigned PALETTE_DEPTH = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // longest busy stretch of the block after its last result
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_LIMIT = 500000;
  localparam int unsigned PRINT_LIMIT = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  item_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  item_out_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 63;
  logic recv_blocked = 1'b0;
  int unsigned fail_count = 0;

  item_in_t items_to_send[$];
  item_out_t drive_expected[$];

  // sequencer state as predicted
  color_t pal_model[PALETTE_DEPTH];
  logic fading_model;
  logic [ELAPSED_W-1:0] elapsed_model;
  logic [SINCE_W-1:0] since_model;
  logic [SLOT_W-1:0] index_model;
  logic [COUNT_W-1:0] count_model;
  logic [ELAPSED_W-1:0] shine_model;
  logic [ELAPSED_W-1:0] fade_model;

  rgb_palette_crossfade_sequencer_core #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    if (fail_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic int unsigned colors_in_use();
    int unsigned c;
    c = int'(count_model);
    if (c == 0) c = 1;
    if (c > PALETTE_DEPTH) c = PALETTE_DEPTH;
    return c;
  endfunction

  function automatic logic [SLOT_W-1:0] following_color(input logic [SLOT_W-1:0] idx);
    int unsigned n;
    n = int'(idx) + 1;
    return (n >= colors_in_use()) ? '0 : SLOT_W'(n);
  endfunction

  // floor((o*(t-e) + n*e) / t), exact
  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] o, input logic [CHAN_W-1:0] n,
                                              input logic [ELAPSED_W-1:0] e,
                                              input logic [ELAPSED_W-1:0] t);
    int unsigned wsum;
    wsum = int'(o) * (int'(t) - int'(e)) + int'(n) * int'(e);
    return CHAN_W'(wsum / int'(t));
  endfunction

  task automatic step_sequencer_model(input item_in_t it);
    color_t from_c;
    color_t to_c;
    item_out_t drv;
    if (it.operation == OP_WRITE) begin
      pal_model[it.slot] = '{red: it.red_in, blue: it.blue_in, green: it.green_in};
      index_model = '0;
    end else begin
      if (elapsed_model != ELAPSED_MAX) elapsed_model++;
      if (since_model != SINCE_MAX) since_model++;
      if (!fading_model) begin
        if (elapsed_model > shine_model) begin
          fading_model = 1'b1;
          elapsed_model = '0;
        end
      end else if (fade_model != 0 && elapsed_model <= fade_model) begin
        if (since_model >= UPDATE_GAP) begin
          since_model = '0;
          from_c = pal_model[index_model];
          to_c = pal_model[following_color(index_model)];
          drv.red_drive = blend(from_c.red, to_c.red, elapsed_model, fade_model);
          drv.blue_drive = blend(from_c.blue, to_c.blue, elapsed_model, fade_model);
          drv.green_drive = blend(from_c.green, to_c.green, elapsed_model, fade_model);
          drive_expected.push_back(drv);
        end
      end else begin
        fading_model = 1'b0;
        elapsed_model = '0;
        index_model = following_color(index_model);
        to_c = pal_model[index_model];
        drv = '{red_drive: to_c.red, blue_drive: to_c.blue, green_drive: to_c.green};
        drive_expected.push_back(drv);
      end
    end
  endtask

  task automatic check_drive(input item_out_t got);
    item_out_t want;
    if (drive_expected.size() == 0) begin
      flag_error($sformatf("unexpected drive %h", got));
    end else begin
      want = drive_expected.pop_front();
      if (got.red_drive !== want.red_drive)
        flag_error($sformatf("red_drive got %h want %h", got.red_drive, want.red_drive));
      if (got.blue_drive !== want.blue_drive)
        flag_error($sformatf("blue_drive got %h want %h", got.blue_drive, want.blue_drive));
      if (got.green_drive !== want.green_drive)
        flag_error($sformatf("green_drive got %h want %h", got.green_drive, want.green_drive));
    end
  endtask

  // driver: a new item only once the current one is transferred
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i <= items_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= recv_blocked || ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_drive(out_item_o);
      if (in_valid_i && !in_stall_o) step_sequencer_model(in_item_i);
    end
  end

  function automatic item_in_t random_item(input op_e op);
    item_in_t it;
    it.operation = op;
    it.slot = SLOT_W'($urandom_range(15));
    it.red_in = CHAN_W'($urandom_range(255));
    it.blue_in = CHAN_W'($urandom_range(255));
    it.green_in = CHAN_W'($urandom_range(255));
    return it;
  endfunction

  function automatic item_in_t palette_write(input logic [SLOT_W-1:0] slot,
                                             input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] b,
                                             input logic [CHAN_W-1:0] g);
    item_in_t it;
    it.operation = OP_WRITE;
    it.slot = slot;
    it.red_in = r;
    it.blue_in = b;
    it.green_in = g;
    return it;
  endfunction

  task automatic queue_ticks(input int unsigned n);
    repeat (n) items_to_send.push_back(random_item(OP_TICK));
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    do begin
      while ((items_to_send.size() != 0 || in_valid_i || drive_expected.size() != 0) &&
             waited < DRAIN_LIMIT) begin
        @(posedge clk_i);
        waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end while ((items_to_send.size() != 0 || in_valid_i || drive_expected.size() != 0) &&
               waited < DRAIN_LIMIT);
    if (drive_expected.size() != 0) begin
      flag_error($sformatf("%0d drive values never arrived", drive_expected.size()));
      drive_expected.delete();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_COLOR_COUNT: count_model = val[COUNT_W-1:0];
      CFG_SHINE_MS: shine_model = val;
      CFG_FADE_MS: fade_model = val;
      default: ;
    endcase
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    @(posedge clk_i);
    recv_blocked <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    recv_blocked <= 1'b0;
  endtask

  // one random setting, a few palette writes, then mostly ticks
  task automatic run_random_block(input int unsigned n_items);
    logic [COUNT_W-1:0] cnt;
    logic [ELAPSED_W-1:0] shine;
    logic [ELAPSED_W-1:0] fade;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) cnt = '0;
    else if (pick == 1) cnt = COUNT_W'($urandom_range(31, PALETTE_DEPTH + 1));
    else cnt = COUNT_W'($urandom_range(PALETTE_DEPTH, 1));
    shine = ($urandom_range(7) == 0) ? 14'd100 : 14'($urandom_range(12));
    pick = $urandom_range(7);
    if (pick == 0) fade = '0;
    else if (pick == 1) fade = 14'd9900;
    else fade = ELAPSED_W'($urandom_range(40, 1));
    write_reg(CFG_COLOR_COUNT, {9'($urandom), cnt});
    write_reg(CFG_SHINE_MS, shine);
    write_reg(CFG_FADE_MS, fade);
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_IDX, 14'($urandom));
    repeat (4) items_to_send.push_back(random_item(OP_WRITE));
    repeat (n_items)
      items_to_send.push_back(random_item(($urandom_range(99) < 3) ? OP_WRITE : OP_TICK));
    wait_drained();
  endtask

  initial begin
    foreach (pal_model[i]) pal_model[i] = COLOR_BLACK;
    pal_model[1] = COLOR_DIM_GREEN;
    fading_model = 1'b0;
    elapsed_model = '0;
    since_model = '0;
    index_model = '0;
    count_model = COUNT_RESET;
    shine_model = SHINE_RESET;
    fade_model = FADE_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers and palette: full hold, then the first mixes toward dim green
    queue_ticks(320);
    wait_drained();

    // directed: ignored register, masked count, zero shine and fade
    write_reg(CFG_UNUSED_IDX, 14'h3FFF);
    write_reg(CFG_COLOR_COUNT, 14'h3FFF);
    write_reg(CFG_SHINE_MS, 14'd0);
    write_reg(CFG_FADE_MS, 14'd0);
    items_to_send.push_back(palette_write(4'd15, 8'hFF, 8'hFF, 8'hFF));
    items_to_send.push_back(palette_write(4'd0, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(palette_write(4'd2, 8'hFF, 8'h00, 8'h80));
    items_to_send.push_back(palette_write(4'd3, 8'h01, 8'hFE, 8'h7F));
    queue_ticks(8);
    wait_drained();
    // index past the count: fade goes toward entry 0
    write_reg(CFG_COLOR_COUNT, 14'd2);
    write_reg(CFG_FADE_MS, 14'd10);
    queue_ticks(10);
    wait_drained();
    // zero count behaves as one color
    write_reg(CFG_COLOR_COUNT, 14'd0);
    write_reg(CFG_FADE_MS, 14'd0);
    queue_ticks(4);
    wait_drained();

    repeat (3) run_random_block(51);

    send_idle_pct = 63;
    recv_idle_pct = 22;
    repeat (3) run_random_block(51);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold with frequent mixes so the block backs up
    write_reg(CFG_COLOR_COUNT, 14'd5);
    write_reg(CFG_SHINE_MS, 14'd1);
    write_reg(CFG_FADE_MS, 14'd40);
    fork
      hold_receiver(400);
    join_none
    queue_ticks(100);
    wait_drained();
    repeat (2) run_random_block(51);

    // largest timer settings: first get to the holding phase
    write_reg(CFG_FADE_MS, 14'd0);
    if (fading_model) begin
      queue_ticks(1);
      wait_drained();
    end
    write_reg(CFG_COLOR_COUNT, 14'd3);
    write_reg(CFG_SHINE_MS, ELAPSED_MAX);
    write_reg(CFG_FADE_MS, ELAPSED_MAX);
    queue_ticks(20);
    wait_drained();
    write_reg(CFG_SHINE_MS, 14'd0);
    queue_ticks(20);
    wait_drained();
    write_reg(CFG_FADE_MS, 14'd12);
    queue_ticks(20);
    wait_drained();

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
